// ===== rtl/tpdts_pkg.sv =====
// package for the triangle pixel depth test and shade block
// types and constants shared by the divider and the top level, and the top level's opcodes
package tpdts_pkg;

  localparam int unsigned ScreenWidth    = 512;
  localparam int unsigned ScreenHeight   = 512;
  localparam int unsigned WeightFracBits = 16;

  localparam int unsigned XBits   = $clog2(ScreenWidth);
  localparam int unsigned YBits   = $clog2(ScreenHeight);
  localparam int unsigned Pixels  = ScreenWidth * ScreenHeight;
  localparam int unsigned AddrW   = $clog2(Pixels);
  localparam int unsigned CrossW  = 36;
  localparam int unsigned NumW    = CrossW + WeightFracBits;
  localparam int unsigned WeightW = WeightFracBits + 1;
  localparam int unsigned DepthW  = 17;

  localparam logic [DepthW-1:0] FarDepth = DepthW'(65535);

  localparam logic OpLoad = 1'b0;
  localparam logic OpTest = 1'b1;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [CrossW-1:0] den;
  } div_req_t;

endpackage

// ===== rtl/tpdts_div.sv =====
// restoring divider, one quotient bit per cycle, saturating at 2^WeightFracBits
// depends on tpdts_pkg
module tpdts_div import tpdts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_req_t            req_i,
  output logic                done_o,
  output logic [WeightW-1:0]  quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]   num_q, num_d;
  logic [NumW-1:0]   quo_q, quo_d;
  logic [CrossW:0]   rem_q, rem_d;
  logic [CrossW-1:0] den_q, den_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CrossW:0]   sh;

  always_comb begin
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    sh = {rem_q[CrossW-1:0], num_q[NumW-1]};
    if (req_i.start) begin
      num_d = req_i.num; den_d = req_i.den; rem_d = '0; quo_d = '0;
      cnt_d = CntW'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = (quo_q > NumW'(1 << WeightFracBits)) ?
                  WeightW'(1 << WeightFracBits) : quo_q[WeightW-1:0];

endmodule

// ===== rtl/triangle_pixel_depth_test_shade.sv =====
// top level: vertex registers, edge tests, weight division, depth store
// depends on tpdts_pkg and tpdts_div
// A load transaction is answered from the idle state. A test transaction that
// misses the triangle or meets a zero area passes the edge and area states and then
// yields its result. A covered pixel goes on through two divisions and the W2, Mul, Sum,
// Rd and Cmp states, and through Out as well when it is written. The two barycentric
// weights come one after the other from a shared divider that yields one quotient bit
// per cycle. The depth store is a 262144 x 17 memory with one read and one write port
// and registered read; it is read and then written. After reset a clearing pass writes
// the far depth into every entry, one a cycle; no item is taken meanwhile.
// One result follows every input item. The output register lets the next item be taken
// while the result waits. A new result that finds the register still full holds the
// block until the register drains.
module triangle_pixel_depth_test_shade import tpdts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op, vertex_sel, vertex_x, vertex_y, vertex_depth, vertex_color, pixel_x, pixel_y
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // written, pixel_index, red, green, blue, depth_out
  output logic [63:0] m_axis_tdata
);

  localparam logic [3:0] StClear = 4'd0, StIdle = 4'd1, StDiv0 = 4'd2, StDiv1 = 4'd3,
                         StW2 = 4'd4, StMul = 4'd5, StSum = 4'd6, StRd = 4'd7,
                         StCmp = 4'd8, StOut = 4'd9, StEdge = 4'd10, StArea = 4'd11,
                         StHold = 4'd12;

  logic [3:0] st_q, st_d;

  logic              op;
  logic [1:0]        sel;
  logic signed [15:0] in_x, in_y, in_z;
  logic [23:0]       in_c;
  logic [8:0]        in_px, in_py;
  assign op = s_axis_tdata[0];
  assign sel = s_axis_tdata[2:1];
  assign in_x = s_axis_tdata[18:3];
  assign in_y = s_axis_tdata[34:19];
  assign in_z = s_axis_tdata[50:35];
  assign in_c = s_axis_tdata[74:51];
  assign in_px = s_axis_tdata[83:75];
  assign in_py = s_axis_tdata[92:84];

  logic signed [15:0] vx_q [3], vy_q [3], vz_q [3];
  logic [23:0]        vc_q [3];

  logic [DepthW-1:0] zmem [Pixels];
  logic [DepthW-1:0] zrd_q;
  logic [AddrW-1:0]  clr_q;

  logic [AddrW-1:0]   idx_q;
  logic signed [17:0] px_q, py_q;
  logic signed [CrossW-1:0] ea_q, eb_q, ec_q, w0n_q, w1n_q, area_q;
  logic [WeightW-1:0] w0_q, w1_q, w2_q;
  logic signed [WeightW+24:0] pz_q [3], pr_q [3], pg_q [3], pb_q [3];
  logic signed [15:0] zo_q;
  logic [7:0]         r_q, g_q, b_q;
  logic               ovalid_q, full_q;
  logic [63:0]        odata_q;

  div_req_t          dreq;
  logic              ddone;
  logic [WeightW-1:0] dq;

  tpdts_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dq));

  function automatic logic signed [CrossW-1:0] cross2(
    input logic signed [17:0] ax, ay, bx, by);
    logic signed [CrossW-1:0] p, q;
    p = CrossW'(ax) * CrossW'(by);
    q = CrossW'(ay) * CrossW'(bx);
    return p - q;
  endfunction

  function automatic logic signed [CrossW-1:0] mag(input logic signed [CrossW-1:0] v);
    return v[CrossW-1] ? -v : v;
  endfunction

  function automatic logic signed [WeightW+9:0] rnd(input logic signed [WeightW+24:0] s);
    logic signed [WeightW+24:0] t;
    t = s + (WeightW+25)'(1 << (WeightFracBits - 1));
    return (WeightW+10)'(t >>> WeightFracBits);
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [WeightW+9:0] v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  logic in_acc, out_acc, can_set;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = ovalid_q && m_axis_tready;
  assign can_set = !full_q || out_acc;
  assign s_axis_tready = (st_q == StIdle);

  logic signed [17:0] sx [3], sy [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sx[i] = 18'(vx_q[i]);
      sy[i] = 18'(vy_q[i]);
    end
  end

  logic               res_set;
  logic [63:0]        res_data;
  logic signed [WeightW+9:0] zr;
  logic signed [15:0] zc;
  logic signed [WeightW+1:0] w2s;
  logic               offs;

  always_comb begin
    zr = rnd(pz_q[0] + pz_q[1] + pz_q[2]);
    zc = (zr < -32768) ? -16'sd32768 : (zr > 32767) ? 16'sd32767 : zr[15:0];
    w2s = (WeightW+2)'(1 << WeightFracBits) - (WeightW+2)'(w0_q) - (WeightW+2)'(w1_q);
    offs = (in_px >= 9'(ScreenWidth - 1) + 9'd1 && ScreenWidth < 512) ||
           (in_py >= 9'(ScreenHeight - 1) + 9'd1 && ScreenHeight < 512);
  end

  always_comb begin
    st_d = st_q; res_set = 1'b0; res_data = '0;
    dreq = '{start: 1'b0, num: '0, den: area_q};
    unique case (st_q)
      StClear: if (clr_q == AddrW'(Pixels - 1)) st_d = StIdle;
      StIdle: if (in_acc) begin
        if (op == OpLoad || offs) begin
          if (can_set) res_set = 1'b1;
          else st_d = StHold;
        end else st_d = StEdge;
      end
      StHold: if (can_set) begin
        res_set = 1'b1; st_d = StIdle;
      end
      StEdge: st_d = StArea;
      StArea: begin
        if (!(((ea_q >= 0) && (eb_q >= 0) && (ec_q >= 0)) ||
              ((ea_q <= 0) && (eb_q <= 0) && (ec_q <= 0))) || area_q == 0) begin
          if (can_set) begin
            res_set = 1'b1; res_data[18:1] = 18'(idx_q); st_d = StIdle;
          end
        end else begin
          dreq.start = 1'b1; dreq.num = NumW'(w0n_q) << WeightFracBits;
          st_d = StDiv0;
        end
      end
      StDiv0: if (ddone) begin
        dreq.start = 1'b1; dreq.num = NumW'(w1n_q) << WeightFracBits;
        st_d = StDiv1;
      end
      StDiv1: if (ddone) st_d = StW2;
      StW2: st_d = StMul;
      StMul: st_d = StSum;
      StSum: st_d = StRd;
      StRd: st_d = StCmp;
      StCmp: begin
        if ($signed({zc[15], zc}) < $signed(zrd_q)) st_d = StOut;
        else if (can_set) begin
          res_set = 1'b1; res_data[18:1] = 18'(idx_q); st_d = StIdle;
        end
      end
      StOut: if (can_set) begin
        res_set = 1'b1;
        res_data = {5'd0, zo_q, b_q, g_q, r_q, 18'(idx_q), 1'b1};
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0; ovalid_q <= 1'b0; full_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0; vy_q[i] <= '0; vz_q[i] <= '0; vc_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= clr_q + 1'b1;
      if (res_set) begin
        ovalid_q <= 1'b1; full_q <= 1'b1;
      end else if (out_acc) begin
        ovalid_q <= 1'b0; full_q <= 1'b0;
      end
      if (in_acc && op == OpLoad && sel != 2'd3) begin
        vx_q[sel] <= in_x; vy_q[sel] <= in_y; vz_q[sel] <= in_z; vc_q[sel] <= in_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_set) odata_q <= res_data;
    zrd_q <= zmem[idx_q];
    if (st_q == StClear) zmem[clr_q] <= FarDepth;
    else if (st_q == StCmp && st_d == StOut) zmem[idx_q] <= {zc[15], zc};
    if (in_acc) begin
      idx_q <= AddrW'(in_py) * AddrW'(ScreenWidth) + AddrW'(in_px);
      px_q <= 18'({in_px, 4'd8});
      py_q <= 18'({in_py, 4'd8});
    end
    if (st_q == StEdge) begin
      ea_q <= cross2(sx[1]-sx[0], sy[1]-sy[0], px_q-sx[0], py_q-sy[0]);
      eb_q <= cross2(sx[2]-sx[1], sy[2]-sy[1], px_q-sx[1], py_q-sy[1]);
      ec_q <= cross2(sx[0]-sx[2], sy[0]-sy[2], px_q-sx[2], py_q-sy[2]);
      area_q <= mag(cross2(sx[1]-sx[0], sy[1]-sy[0], sx[2]-sx[0], sy[2]-sy[0]));
      w0n_q <= mag(cross2(sx[1]-px_q, sy[1]-py_q, sx[2]-px_q, sy[2]-py_q));
      w1n_q <= mag(cross2(sx[2]-px_q, sy[2]-py_q, sx[0]-px_q, sy[0]-py_q));
    end
    if (st_q == StDiv0 && ddone) w0_q <= dq;
    if (st_q == StDiv1 && ddone) w1_q <= dq;
    if (st_q == StW2) w2_q <= w2s[WeightW+1] ? '0 : w2s[WeightW-1:0];
    if (st_q == StMul) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [WeightW:0] w;
        w = (i == 0) ? {1'b0, w0_q} : (i == 1) ? {1'b0, w1_q} : {1'b0, w2_q};
        pz_q[i] <= (WeightW+25)'(w) * (WeightW+25)'(vz_q[i]);
        pr_q[i] <= (WeightW+25)'(w) * (WeightW+25)'({1'b0, vc_q[i][23:16]});
        pg_q[i] <= (WeightW+25)'(w) * (WeightW+25)'({1'b0, vc_q[i][15:8]});
        pb_q[i] <= (WeightW+25)'(w) * (WeightW+25)'({1'b0, vc_q[i][7:0]});
      end
    end
    if (st_q == StCmp) begin
      zo_q <= zc;
      r_q <= clamp8(rnd(pr_q[0] + pr_q[1] + pr_q[2]));
      g_q <= clamp8(rnd(pg_q[0] + pg_q[1] + pg_q[2]));
      b_q <= clamp8(rnd(pb_q[0] + pb_q[1] + pb_q[2]));
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;

`ifndef ASSERT_OFF
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StClear |-> !s_axis_tready) else $error("accept during clear");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_set |-> !full_q || out_acc) else $error("result overwritten");
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> !in_acc) else $error("accept while busy");
`endif

endmodule
